// ----- rtl/core/assert_macros.svh -----
// assertion macros for the clipper rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define RLC_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define RLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rlc_pkg.sv -----
// shared types and constants for the rectangle line clipper
package rlc_pkg;

   localparam int COORD_BITS   = 16;
   localparam int CW           = COORD_BITS + 6;   // internal signed coordinate width
   localparam int UW           = COORD_BITS + 4;   // ratio operand magnitude width
   localparam int QB           = UW;               // quotient bits, one per divider stage
   localparam int RW           = UW + 2;           // partial remainder width
   localparam int NW           = 2 * UW + 2;       // numerator width, 2ab + c
   localparam int RATIO_STAGES = QB + 2;
   localparam int QD           = 4;                // queue depth
   localparam int QAW          = $clog2(QD);
   localparam int CSR_IW       = 2;

   localparam logic [CSR_IW-1:0] CSR_X_MIN = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_X_MAX = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_Y_MIN = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_Y_MAX = 2'd3;

   typedef logic signed [CW-1:0] crd_type;
   typedef logic [UW-1:0]        mag_type;

   typedef struct packed {
      logic    pass;      // both ends inside, goes out unchanged
      logic    reject;
      logic    fx;
      logic    fy;
      logic    slanted;
      crd_type x1;
      crd_type y1;
      crd_type x2;
      crd_type y2;
      crd_type xmi;
      crd_type xma;
      crd_type ymi;
      crd_type yma;
      crd_type dx;
      crd_type dy;
   } seg_type;

endpackage

// ----- rtl/core/rect_line_clipper.sv -----
// top level of the rectangle line clipper
// Clips one segment (start, end) against a rectangle held in four csr registers.
// Input: a segment is taken at a rising edge with start high and busy low.
// Output: each segment gives exactly one result beat, rsp_valid high for one cycle,
// with rsp_visible and the clipped end points (all zero when rejected).
// On its way the beat passes the front register, the queue, four chained ratio
// pipelines, each one multiply stage and one quotient bit per stage, and the
// output register. Throughput is one segment per cycle; busy only rises while
// the queue holds QD-1 entries or more.
// Csr writes (csr_we, csr_index, csr_wdata) land at once, with no read-back; they
// are meant for idle periods. Reset empties all pipelines and the queue and sets
// the rectangle to x and y from 0 to the largest positive coordinate.
// Results are never held: the receiver takes every beat.
module rect_line_clipper import rlc_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   output logic                         rsp_visible,
   output logic signed [COORD_BITS-1:0] rsp_out_start_x,
   output logic signed [COORD_BITS-1:0] rsp_out_start_y,
   output logic signed [COORD_BITS-1:0] rsp_out_end_x,
   output logic signed [COORD_BITS-1:0] rsp_out_end_y,
   input  logic                         csr_we,
   input  logic [CSR_IW-1:0]            csr_index,
   input  logic [COORD_BITS-1:0]        csr_wdata
);

   localparam logic signed [COORD_BITS-1:0] MAX_POS = {1'b0, {(COORD_BITS-1){1'b1}}};

   logic signed [COORD_BITS-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic                         accept;
   logic                         f_valid, q_valid, q_almost_full;
   seg_type                      f_seg, q_seg;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= '0;
         x_max_ff <= MAX_POS;
         y_min_ff <= '0;
         y_max_ff <= MAX_POS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_X_MIN: x_min_ff <= csr_wdata;
            CSR_X_MAX: x_max_ff <= csr_wdata;
            CSR_Y_MIN: y_min_ff <= csr_wdata;
            CSR_Y_MAX: y_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy   = q_almost_full;
   assign accept = start && !busy;

   rlc_front u_front (
      .clock(clock), .reset(reset), .accept(accept),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .x_min(x_min_ff), .x_max(x_max_ff), .y_min(y_min_ff), .y_max(y_max_ff),
      .out_valid(f_valid), .out_seg(f_seg)
   );

   rlc_queue u_queue (
      .clock(clock), .reset(reset),
      .push(f_valid), .push_seg(f_seg),
      .pop(q_valid),
      .out_valid(q_valid), .out_seg(q_seg), .almost_full(q_almost_full)
   );

   rlc_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_seg(q_seg),
      .rsp_valid(rsp_valid), .rsp_visible(rsp_visible),
      .rsp_out_start_x(rsp_out_start_x), .rsp_out_start_y(rsp_out_start_y),
      .rsp_out_end_x(rsp_out_end_x), .rsp_out_end_y(rsp_out_end_y)
   );

endmodule

// ----- rtl/core/rlc_front.sv -----
// front end: runs trivial tests, mirrors a non-pass segment to increasing x and y
module rlc_front import rlc_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic signed [COORD_BITS-1:0] x_min,
   input  logic signed [COORD_BITS-1:0] x_max,
   input  logic signed [COORD_BITS-1:0] y_min,
   input  logic signed [COORD_BITS-1:0] y_max,
   output logic                         out_valid,
   output seg_type                      out_seg
);

   logic    vld_ff, vld_in;
   seg_type seg_ff, seg_in;

   always_comb begin
      crd_type x1, y1, x2, y2, xmi, xma, ymi, yma;
      logic    in_rect, rej;
      x1  = crd_type'(req_start_x);
      y1  = crd_type'(req_start_y);
      x2  = crd_type'(req_end_x);
      y2  = crd_type'(req_end_y);
      xmi = crd_type'(x_min);
      xma = crd_type'(x_max);
      ymi = crd_type'(y_min);
      yma = crd_type'(y_max);
      in_rect = (x1 >= xmi) && (x1 <= xma) && (y1 >= ymi) && (y1 <= yma) &&
                (x2 >= xmi) && (x2 <= xma) && (y2 >= ymi) && (y2 <= yma);
      rej = ((x1 <= xmi) && (x2 <= xmi)) || ((x1 >= xma) && (x2 >= xma)) ||
            ((y1 <= ymi) && (y2 <= ymi)) || ((y1 >= yma) && (y2 >= yma));
      seg_in        = '0;
      seg_in.pass   = in_rect;
      seg_in.reject = !in_rect && rej;
      if (!in_rect && (x2 < x1)) begin
         x1  = xmi + xmi - x1;
         x2  = xmi + xmi - x2;
         xma = xmi + xmi - xma;
         // swap edges: old min becomes max
         {xmi, xma} = {xma, xmi};
         seg_in.fx = 1'b1;
      end
      if (!in_rect && (y2 < y1)) begin
         y1  = ymi + ymi - y1;
         y2  = ymi + ymi - y2;
         yma = ymi + ymi - yma;
         {ymi, yma} = {yma, ymi};
         seg_in.fy = 1'b1;
      end
      seg_in.x1  = x1;
      seg_in.y1  = y1;
      seg_in.x2  = x2;
      seg_in.y2  = y2;
      seg_in.xmi = xmi;
      seg_in.xma = xma;
      seg_in.ymi = ymi;
      seg_in.yma = yma;
      seg_in.dx  = x2 - x1;
      seg_in.dy  = y2 - y1;
      seg_in.slanted = (x2 != x1) && (y2 != y1);
      vld_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      seg_ff <= seg_in;
   end

   assign out_valid = vld_ff;
   assign out_seg   = seg_ff;

endmodule

// ----- rtl/core/rlc_queue.sv -----
// short queue between the classifying front end and the clipping back end
`include "assert_macros.svh"
module rlc_queue import rlc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  seg_type push_seg,
   input  logic    pop,
   output logic    out_valid,
   output seg_type out_seg,
   output logic    almost_full
);

   seg_type        mem_ff [QD];
   logic [QAW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QAW:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_seg;
      end
   end

   assign out_valid   = (cnt_ff != '0);
   assign out_seg     = mem_ff[rd_ff];
   // one slot kept free for the beat already in the front register
   assign almost_full = (cnt_ff >= (QAW+1)'(QD - 1));

   `RLC_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= (QAW+1)'(QD), "queue count overflow")
   `RLC_ASSERT_ALWAYS(a_no_push_full, clock, reset, !(push && !pop && cnt_ff == (QAW+1)'(QD)), "push into full queue")
   `RLC_ASSERT_NEXT(a_pop_moves, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 1'b1, "pop did not drain")

endmodule

// ----- rtl/core/rlc_ratio.sv -----
// pipelined round(a*b/c) half away from zero: one multiply stage, one quotient bit per stage
module rlc_ratio import rlc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  seg_type in_seg,
   input  logic    in_en,
   input  mag_type in_a,
   input  mag_type in_b,
   input  mag_type in_c,
   output logic    out_valid,
   output seg_type out_seg,
   output mag_type out_q
);

   localparam int ST = RATIO_STAGES;

   logic [ST-1:0]   vld_ff;
   logic [ST-1:0]   en_ff;
   seg_type         seg_ff [ST];
   mag_type         a_ff, b_ff, c_ff;
   logic [RW-1:0]   rem_ff [1:ST-1];
   logic [QB-1:0]   low_ff [1:ST-1];
   logic [QB-1:0]   quo_ff [1:ST-1];
   logic [RW-1:0]   d_ff   [1:ST-1];

   logic [2*UW-1:0] prod;
   logic [NW-1:0]   num_in;
   logic [RW-1:0]   t_in   [2:ST-1];
   logic [RW-1:0]   rem_in [2:ST-1];
   logic [QB-1:0]   low_in [2:ST-1];
   logic [QB-1:0]   quo_in [2:ST-1];

   always_comb begin
      prod   = a_ff * b_ff;
      // numerator 2ab + c over divisor 2c gives the rounded ratio
      num_in = {1'b0, prod, 1'b0} + {{(NW-UW){1'b0}}, c_ff};
      for (int j = 2; j < ST; j++) begin
         t_in[j]   = {rem_ff[j-1][RW-2:0], low_ff[j-1][QB-1]};
         low_in[j] = {low_ff[j-1][QB-2:0], 1'b0};
         if (t_in[j] >= d_ff[j-1]) begin
            rem_in[j] = t_in[j] - d_ff[j-1];
            quo_in[j] = {quo_ff[j-1][QB-2:0], 1'b1};
         end else begin
            rem_in[j] = t_in[j];
            quo_in[j] = {quo_ff[j-1][QB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ST-2:0], in_valid};
      end
      en_ff     <= {en_ff[ST-2:0], in_en};
      seg_ff[0] <= in_seg;
      for (int j = 1; j < ST; j++) begin
         seg_ff[j] <= seg_ff[j-1];
      end
      a_ff <= in_en ? in_a : '0;
      b_ff <= in_b;
      c_ff <= in_c;
      rem_ff[1] <= num_in[NW-1:QB];
      low_ff[1] <= num_in[QB-1:0];
      quo_ff[1] <= '0;
      d_ff[1]   <= {1'b0, c_ff, 1'b0};
      for (int j = 2; j < ST; j++) begin
         rem_ff[j] <= rem_in[j];
         low_ff[j] <= low_in[j];
         quo_ff[j] <= quo_in[j];
         d_ff[j]   <= d_ff[j-1];
      end
   end

   assign out_valid = vld_ff[ST-1];
   assign out_seg   = seg_ff[ST-1];
   assign out_q     = en_ff[ST-1] ? quo_ff[ST-1] : '0;

endmodule

// ----- rtl/core/rlc_back.sv -----
// back end: moves the ends onto the edges through four ratio pipelines, mirrors back
module rlc_back import rlc_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  seg_type                      in_seg,
   output logic                         rsp_valid,
   output logic                         rsp_visible,
   output logic signed [COORD_BITS-1:0] rsp_out_start_x,
   output logic signed [COORD_BITS-1:0] rsp_out_start_y,
   output logic signed [COORD_BITS-1:0] rsp_out_end_x,
   output logic signed [COORD_BITS-1:0] rsp_out_end_y
);

   logic    o1_valid, o2_valid, o3_valid, o4_valid;
   seg_type o1_seg, o2_seg, o3_seg, o4_seg;
   mag_type o1_q, o2_q, o3_q, o4_q;
   seg_type s1, s2, s3, s4;
   logic    en1, en2, en3, en4;
   mag_type a1, a2, a3, a4;
   crd_type d1, d2, d3, d4;

   logic                         vld_ff, vld_in;
   logic                         vis_ff, vis_in;
   logic signed [COORD_BITS-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [COORD_BITS-1:0] sx_in, sy_in, ex_in, ey_in;

   // start onto the x min edge
   always_comb begin
      d1  = in_seg.xmi - in_seg.x1;
      a1  = d1[UW-1:0];
      en1 = !in_seg.pass && !in_seg.reject && in_seg.slanted && (in_seg.x1 < in_seg.xmi);
   end

   rlc_ratio u_ratio1 (
      .clock(clock), .reset(reset),
      .in_valid(in_valid), .in_seg(in_seg), .in_en(en1),
      .in_a(a1), .in_b(in_seg.dy[UW-1:0]), .in_c(in_seg.dx[UW-1:0]),
      .out_valid(o1_valid), .out_seg(o1_seg), .out_q(o1_q)
   );

   // start onto the y min edge
   always_comb begin
      s1 = o1_seg;
      if (!s1.pass && !s1.reject && (s1.x1 < s1.xmi)) begin
         s1.y1 = s1.y1 + crd_type'(o1_q);
         s1.x1 = s1.xmi;
      end
      d2  = s1.ymi - s1.y1;
      a2  = d2[UW-1:0];
      en2 = !s1.pass && !s1.reject && s1.slanted && (s1.y1 < s1.ymi);
   end

   rlc_ratio u_ratio2 (
      .clock(clock), .reset(reset),
      .in_valid(o1_valid), .in_seg(s1), .in_en(en2),
      .in_a(a2), .in_b(s1.dx[UW-1:0]), .in_c(s1.dy[UW-1:0]),
      .out_valid(o2_valid), .out_seg(o2_seg), .out_q(o2_q)
   );

   // post-clip reject, then end onto the y max edge
   always_comb begin
      s2 = o2_seg;
      if (!s2.pass && !s2.reject && (s2.y1 < s2.ymi)) begin
         s2.x1 = s2.x1 + crd_type'(o2_q);
         s2.y1 = s2.ymi;
      end
      if (!s2.pass && !s2.reject && ((s2.x1 >= s2.xma) || (s2.y1 >= s2.yma))) begin
         s2.reject = 1'b1;
      end
      d3  = s2.y2 - s2.yma;
      a3  = d3[UW-1:0];
      en3 = !s2.pass && !s2.reject && s2.slanted && (s2.y2 > s2.yma);
   end

   rlc_ratio u_ratio3 (
      .clock(clock), .reset(reset),
      .in_valid(o2_valid), .in_seg(s2), .in_en(en3),
      .in_a(a3), .in_b(s2.dx[UW-1:0]), .in_c(s2.dy[UW-1:0]),
      .out_valid(o3_valid), .out_seg(o3_seg), .out_q(o3_q)
   );

   // end onto the x max edge
   always_comb begin
      s3 = o3_seg;
      if (!s3.pass && !s3.reject && (s3.y2 > s3.yma)) begin
         s3.x2 = s3.x2 - crd_type'(o3_q);
         s3.y2 = s3.yma;
      end
      d4  = s3.x2 - s3.xma;
      a4  = d4[UW-1:0];
      en4 = !s3.pass && !s3.reject && s3.slanted && (s3.x2 > s3.xma);
   end

   rlc_ratio u_ratio4 (
      .clock(clock), .reset(reset),
      .in_valid(o3_valid), .in_seg(s3), .in_en(en4),
      .in_a(a4), .in_b(s3.dy[UW-1:0]), .in_c(s3.dx[UW-1:0]),
      .out_valid(o4_valid), .out_seg(o4_seg), .out_q(o4_q)
   );

   // mirror back and form the result beat
   always_comb begin
      s4 = o4_seg;
      if (!s4.pass && !s4.reject) begin
         if (s4.x2 > s4.xma) begin
            s4.y2 = s4.y2 - crd_type'(o4_q);
            s4.x2 = s4.xma;
         end
         if (s4.fx) begin
            s4.x1 = s4.xma + s4.xma - s4.x1;
            s4.x2 = s4.xma + s4.xma - s4.x2;
         end
         if (s4.fy) begin
            s4.y1 = s4.yma + s4.yma - s4.y1;
            s4.y2 = s4.yma + s4.yma - s4.y2;
         end
      end
      vld_in = o4_valid;
      vis_in = !s4.reject;
      sx_in  = s4.reject ? '0 : s4.x1[COORD_BITS-1:0];
      sy_in  = s4.reject ? '0 : s4.y1[COORD_BITS-1:0];
      ex_in  = s4.reject ? '0 : s4.x2[COORD_BITS-1:0];
      ey_in  = s4.reject ? '0 : s4.y2[COORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      vis_ff <= vis_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      ex_ff  <= ex_in;
      ey_ff  <= ey_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_visible     = vis_ff;
   assign rsp_out_start_x = sx_ff;
   assign rsp_out_start_y = sy_ff;
   assign rsp_out_end_x   = ex_ff;
   assign rsp_out_end_y   = ey_ff;

endmodule
